>>> design/i2crm_pkg.sv
// i2crm_pkg: types and constants shared by the i2c register master
// used by the front queue, the bus sequencer, the top level and the checker
package i2crm_pkg;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_BUS_BUSY  = 3'd1;
    localparam logic [2:0] STAT_BUS_ERR   = 3'd2;
    localparam logic [2:0] STAT_ADDR_NACK = 3'd3;
    localparam logic [2:0] STAT_DATA_NACK = 3'd4;

    localparam logic [15:0] DELAY_RESET = 16'd5;
    localparam logic [7:0]  ADDR_MASK   = 8'hFE;
    localparam logic [7:0]  ADDR_RD_BIT = 8'h01;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_ST3,
        PH_TXA, PH_TXB, PH_TXC,
        PH_WAA, PH_WAB, PH_WAC,
        PH_RXA, PH_RXB,
        PH_AKA, PH_AKB, PH_AKC, PH_AKD,
        PH_SPA, PH_SPB, PH_SPC, PH_SPD
    } t_phase;

    typedef enum logic [2:0] {
        STG_ADDR, STG_REG, STG_DATA, STG_RSTART, STG_RADDR
    } t_stage;

    typedef struct packed {
        logic [1:0] kind;
        logic       sda_in;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [4:0] byte_count;
        logic [7:0] write_byte;
    } t_in_word;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_data;
        logic       done_res;
        logic [2:0] status;
    } t_out_word;

    typedef struct packed {
        logic is_tick;
        logic is_load;
        logic is_start;
        logic is_read;
    } t_cmd;

    typedef struct packed {
        t_cmd     cmd;
        t_in_word word;
    } t_queue_entry;

    typedef struct packed {
        logic         valid;
        t_queue_entry entry;
    } t_front;

endpackage

>>> design/i2crm_front.sv
// i2crm_front: input side, classifies each word and holds it in a two-entry queue
// depends on i2crm_pkg
module i2crm_front
    import i2crm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_word i_in_word,
    output t_front   o_front,
    input  logic     i_pop
);

    t_queue_entry r_q [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         push;
    t_cmd         cmd;

    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;

    always_comb begin
        cmd.is_tick  = (i_in_word.kind == KIND_TICK);
        cmd.is_load  = (i_in_word.kind == KIND_LOAD);
        cmd.is_start = (i_in_word.kind == KIND_WRITE) || (i_in_word.kind == KIND_READ);
        cmd.is_read  = (i_in_word.kind == KIND_READ);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{cmd: cmd, word: i_in_word};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, i_pop};
        end
    end

    assign o_front.valid = (r_count != 2'd0);
    assign o_front.entry = r_q[r_rd_ptr];

endmodule

>>> design/i2crm_seq.sv
// i2crm_seq: bus sequencer, write buffer, delay register and result register
// depends on i2crm_pkg, fed by i2crm_front
module i2crm_seq
    import i2crm_pkg::*;
#(
    parameter int MAX_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_front      i_front,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    localparam int CW   = $clog2(MAX_BYTES + 1);
    localparam int AW   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CMPW = (CW > 5) ? CW : 5;

    logic [7:0]    r_mem [MAX_BYTES];
    logic [7:0]    r_rdata;
    logic [15:0]   r_delay_ticks;

    t_phase        r_phase,     n_phase;
    logic [15:0]   r_delay_cnt, n_delay_cnt;
    logic [3:0]    r_bit_cnt,   n_bit_cnt;
    logic [7:0]    r_shift,     n_shift;
    logic [CW-1:0] r_byte_idx,  n_byte_idx;
    logic [CW-1:0] r_fill,      n_fill;
    logic [7:0]    r_addr,      n_addr;
    logic [7:0]    r_reg,       n_reg;
    logic [CW-1:0] r_count,     n_count;
    logic          r_read_mode, n_read_mode;
    logic          r_scl,       n_scl;
    logic          r_sda,       n_sda;
    t_stage        r_stage,     n_stage;
    logic [2:0]    r_end_stat,  n_end_stat;
    logic          r_out_valid;
    t_out_word     r_out;

    logic          step;
    logic          mem_we;
    logic [AW-1:0] rd_addr;
    logic [15:0]   dcnt_inc;
    logic [CW-1:0] idx_inc;
    logic [CMPW-1:0] cnt_ext;
    logic          ev_done;
    logic [2:0]    ev_status;
    logic          ev_got;
    logic [7:0]    ev_data;
    logic [3:0]    bit_inc;
    logic [7:0]    rx_byte;
    t_in_word      w;
    t_cmd          c;
    t_out_word     result;

    assign step  = i_front.valid && (!r_out_valid || !i_out_stall);
    assign o_pop = step;
    assign w     = i_front.entry.word;
    assign c     = i_front.entry.cmd;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_delay_cnt = r_delay_cnt;
        n_bit_cnt   = r_bit_cnt;
        n_shift     = r_shift;
        n_byte_idx  = r_byte_idx;
        n_fill      = r_fill;
        n_addr      = r_addr;
        n_reg       = r_reg;
        n_count     = r_count;
        n_read_mode = r_read_mode;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_stage     = r_stage;
        n_end_stat  = r_end_stat;
        mem_we      = 1'b0;
        ev_done     = 1'b0;
        ev_status   = STAT_OK;
        ev_got      = 1'b0;
        ev_data     = 8'd0;
        dcnt_inc    = r_delay_cnt + 16'd1;
        idx_inc     = r_byte_idx + CW'(1);
        bit_inc     = r_bit_cnt + 4'd1;
        rx_byte     = {r_shift[6:0], w.sda_in};
        cnt_ext     = CMPW'(w.byte_count);
        if (step) begin
            if (c.is_tick) begin
                if (r_phase != PH_IDLE) begin
                    n_delay_cnt = dcnt_inc;
                    if (dcnt_inc >= r_delay_ticks) begin
                        n_delay_cnt = 16'd0;
                        unique case (r_phase)
                            PH_ST1: begin
                                if (r_stage == STG_ADDR && !w.sda_in) begin
                                    n_phase   = PH_IDLE;
                                    ev_done   = 1'b1;
                                    ev_status = STAT_BUS_BUSY;
                                end else begin
                                    n_sda   = 1'b0;
                                    n_phase = PH_ST2;
                                end
                            end
                            PH_ST2: begin
                                if (r_stage == STG_ADDR && w.sda_in) begin
                                    n_phase   = PH_IDLE;
                                    ev_done   = 1'b1;
                                    ev_status = STAT_BUS_ERR;
                                end else begin
                                    n_sda   = 1'b0;
                                    n_phase = PH_ST3;
                                end
                            end
                            PH_ST3: begin
                                n_bit_cnt = 4'd0;
                                n_scl     = 1'b0;
                                n_phase   = PH_TXA;
                                if (r_stage == STG_RSTART) begin
                                    n_stage = STG_RADDR;
                                    n_shift = (r_addr & ADDR_MASK) | ADDR_RD_BIT;
                                end else begin
                                    n_shift = r_addr & ADDR_MASK;
                                end
                            end
                            PH_TXA: begin
                                n_sda   = r_shift[7];
                                n_shift = {r_shift[6:0], 1'b0};
                                n_phase = PH_TXB;
                            end
                            PH_TXB: begin
                                n_scl   = 1'b1;
                                n_phase = PH_TXC;
                            end
                            PH_TXC: begin
                                n_bit_cnt = bit_inc;
                                n_scl     = 1'b0;
                                n_phase   = (bit_inc < 4'd8) ? PH_TXA : PH_WAA;
                            end
                            PH_WAA: begin
                                n_sda   = 1'b1;
                                n_phase = PH_WAB;
                            end
                            PH_WAB: begin
                                n_scl   = 1'b1;
                                n_phase = PH_WAC;
                            end
                            PH_WAC: begin
                                n_scl = 1'b0;
                                unique case (r_stage)
                                    STG_ADDR: begin
                                        if (w.sda_in) begin
                                            n_end_stat = STAT_ADDR_NACK;
                                            n_phase    = PH_SPA;
                                        end else begin
                                            n_stage   = STG_REG;
                                            n_shift   = r_reg;
                                            n_bit_cnt = 4'd0;
                                            n_phase   = PH_TXA;
                                        end
                                    end
                                    STG_REG: begin
                                        if (r_read_mode) begin
                                            n_stage = STG_RSTART;
                                            n_sda   = 1'b1;
                                            n_scl   = 1'b1;
                                            n_phase = PH_ST1;
                                        end else begin
                                            n_byte_idx = '0;
                                            if (r_count != '0) begin
                                                n_stage   = STG_DATA;
                                                n_shift   = r_rdata;
                                                n_bit_cnt = 4'd0;
                                                n_phase   = PH_TXA;
                                            end else begin
                                                n_end_stat = STAT_OK;
                                                n_phase    = PH_SPA;
                                            end
                                        end
                                    end
                                    STG_DATA: begin
                                        if (w.sda_in) begin
                                            n_end_stat = STAT_DATA_NACK;
                                            n_phase    = PH_SPA;
                                        end else begin
                                            n_byte_idx = idx_inc;
                                            if (idx_inc < r_count) begin
                                                n_shift   = r_rdata;
                                                n_bit_cnt = 4'd0;
                                                n_phase   = PH_TXA;
                                            end else begin
                                                n_end_stat = STAT_OK;
                                                n_phase    = PH_SPA;
                                            end
                                        end
                                    end
                                    default: begin
                                        n_byte_idx = '0;
                                        if (r_count != '0) begin
                                            n_sda     = 1'b1;
                                            n_shift   = 8'd0;
                                            n_bit_cnt = 4'd0;
                                            n_phase   = PH_RXA;
                                        end else begin
                                            n_end_stat = STAT_OK;
                                            n_phase    = PH_SPA;
                                        end
                                    end
                                endcase
                            end
                            PH_RXA: begin
                                n_scl   = 1'b1;
                                n_phase = PH_RXB;
                            end
                            PH_RXB: begin
                                n_shift   = rx_byte;
                                n_bit_cnt = bit_inc;
                                n_scl     = 1'b0;
                                if (bit_inc < 4'd8) begin
                                    n_phase = PH_RXA;
                                end else begin
                                    ev_got  = 1'b1;
                                    ev_data = rx_byte;
                                    n_phase = PH_AKA;
                                end
                            end
                            PH_AKA: begin
                                n_sda   = ({1'b0, r_byte_idx} + (CW+1)'(1)) >= {1'b0, r_count};
                                n_phase = PH_AKB;
                            end
                            PH_AKB: begin
                                n_scl   = 1'b1;
                                n_phase = PH_AKC;
                            end
                            PH_AKC: begin
                                n_scl   = 1'b0;
                                n_phase = PH_AKD;
                            end
                            PH_AKD: begin
                                n_byte_idx = idx_inc;
                                if (idx_inc < r_count) begin
                                    n_sda     = 1'b1;
                                    n_shift   = 8'd0;
                                    n_bit_cnt = 4'd0;
                                    n_phase   = PH_RXA;
                                end else begin
                                    n_end_stat = STAT_OK;
                                    n_phase    = PH_SPA;
                                end
                            end
                            PH_SPA: begin
                                n_sda   = 1'b0;
                                n_phase = PH_SPB;
                            end
                            PH_SPB: begin
                                n_scl   = 1'b1;
                                n_phase = PH_SPC;
                            end
                            PH_SPC: begin
                                n_sda   = 1'b1;
                                n_phase = PH_SPD;
                            end
                            PH_SPD: begin
                                n_phase   = PH_IDLE;
                                ev_done   = 1'b1;
                                ev_status = r_end_stat;
                            end
                            default: begin
                                n_phase = PH_IDLE;
                                ev_done = 1'b1;
                            end
                        endcase
                        // entering stop always drops scl first
                        if (n_phase == PH_SPA && r_phase != PH_SPA) begin
                            n_scl = 1'b0;
                        end
                    end
                end
            end else if (r_phase == PH_IDLE) begin
                if (c.is_load) begin
                    if (r_fill < CW'(MAX_BYTES)) begin
                        mem_we = 1'b1;
                        n_fill = r_fill + CW'(1);
                    end
                end else if (c.is_start) begin
                    n_addr      = w.device_address & ADDR_MASK;
                    n_reg       = w.register_address;
                    n_byte_idx  = '0;
                    n_bit_cnt   = 4'd0;
                    n_read_mode = c.is_read;
                    if (c.is_read) begin
                        n_count = (cnt_ext < CMPW'(MAX_BYTES)) ? CW'(cnt_ext)
                                                               : CW'(MAX_BYTES);
                    end else begin
                        n_count = (cnt_ext < CMPW'(r_fill)) ? CW'(cnt_ext) : r_fill;
                        n_fill  = '0;
                    end
                    n_stage     = STG_ADDR;
                    n_sda       = 1'b1;
                    n_scl       = 1'b1;
                    n_delay_cnt = 16'd0;
                    n_phase     = PH_ST1;
                end
            end
        end
    end

    // result word
    always_comb begin
        result.scl_out    = n_scl;
        result.sda_out    = n_sda;
        result.busy_res   = (n_phase != PH_IDLE);
        result.read_valid = ev_got;
        result.read_data  = ev_data;
        result.done_res   = ev_done;
        result.status     = ev_status;
    end

    // prefetch of the next byte to send
    assign rd_addr = (n_stage == STG_DATA) ? AW'(n_byte_idx + CW'(1)) : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'(r_fill)] <= w.write_byte;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_ticks <= DELAY_RESET;
            r_phase       <= PH_IDLE;
            r_delay_cnt   <= 16'd0;
            r_bit_cnt     <= 4'd0;
            r_shift       <= 8'd0;
            r_byte_idx    <= '0;
            r_fill        <= '0;
            r_addr        <= 8'd0;
            r_reg         <= 8'd0;
            r_count       <= '0;
            r_read_mode   <= 1'b0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_stage       <= STG_ADDR;
            r_end_stat    <= STAT_OK;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_delay_ticks <= i_cfg_wr_data;
            end
            r_phase     <= n_phase;
            r_delay_cnt <= n_delay_cnt;
            r_bit_cnt   <= n_bit_cnt;
            r_shift     <= n_shift;
            r_byte_idx  <= n_byte_idx;
            r_fill      <= n_fill;
            r_addr      <= n_addr;
            r_reg       <= n_reg;
            r_count     <= n_count;
            r_read_mode <= n_read_mode;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_stage     <= n_stage;
            r_end_stat  <= n_end_stat;
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

>>> design/i2c_register_master_unit.sv
// channel   direction  handshake                  word
// input     in         i_in_valid / o_in_stall    t_in_word  (tick, load, write, read)
// result    out        o_out_valid / i_out_stall  t_out_word (line drive, data, status)
// config    in         i_cfg_wr_en                i_cfg_wr_data (delay_ticks)
//
// one word per cycle sustained while the result is not stalled; each word passes from input to result
// through the two-entry input queue, then through the sequencer into the result register
// one result per input word, in order
// synchronous active-low reset: bus lines released, delay_ticks back to 5, queues empty
// a stalled result holds and the input queue keeps taking words until it is full
// depends on i2crm_pkg, i2crm_front, i2crm_seq
module i2c_register_master_unit
    import i2crm_pkg::*;
#(
    parameter int MAX_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    t_front front;
    logic   pop;

    i2crm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_front    (front),
        .i_pop      (pop)
    );

    i2crm_seq #(
        .MAX_BYTES (MAX_BYTES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_front       (front),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

endmodule

>>> design/i2crm_checker.sv
// i2crm_props: port-level checks on the i2c register master, bound to the top level
// depends on i2crm_pkg
module i2crm_props
    import i2crm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("word pending after reset");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.done_res |-> o_out_word.status == STAT_OK)
        else $error("status without done");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.done_res |-> !o_out_word.busy_res)
        else $error("done while still busy");

    a_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.read_valid |-> o_out_word.read_data == 8'd0)
        else $error("read data without read valid");

endmodule

bind i2c_register_master_unit i2crm_props u_checker (.*);
